// ===== sv/rdc_pkg.sv =====
package rdc_pkg;

   // Width of the ciphertext, plaintext and modulus datapath.
   localparam int DATA_W = 64;
   localparam int CNT_W  = $clog2(DATA_W);
   localparam int IDX_W  = 3;

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] REG_MODE = 3'd0;
   localparam logic [IDX_W-1:0] REG_P    = 3'd1;
   localparam logic [IDX_W-1:0] REG_Q    = 3'd2;
   localparam logic [IDX_W-1:0] REG_D    = 3'd3;
   localparam logic [IDX_W-1:0] REG_DP   = 3'd4;
   localparam logic [IDX_W-1:0] REG_DQ   = 3'd5;
   localparam logic [IDX_W-1:0] REG_WP   = 3'd6;
   localparam logic [IDX_W-1:0] REG_WQ   = 3'd7;

   // Operations of the bit-serial modular unit.
   typedef enum logic {
      OP_REDUCE,
      OP_MULT
   } mmu_op_type;

   // Command from the sequencer to the modular unit.
   typedef struct packed {
      logic              start;
      mmu_op_type        op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] m;
   } mmu_req_type;

   // Which exponentiation is in progress.
   typedef enum logic [1:0] {
      LEG_DIRECT,
      LEG_P,
      LEG_Q
   } leg_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MODN,
      ST_SEL,
      ST_BRED,
      ST_BRED_W,
      ST_SQ,
      ST_SQ_W,
      ST_ML,
      ST_ML_W,
      ST_PEND,
      ST_WRED,
      ST_WRED_W,
      ST_WMUL,
      ST_WMUL_W,
      ST_SUM,
      ST_OUT
   } state_type;

endpackage

// ===== sv/rdc_mmu.sv =====
module rdc_mmu (
   input  logic                        clock,
   input  logic                        reset,
   input  rdc_pkg::mmu_req_type        req,
   output logic                        done,
   output logic [rdc_pkg::DATA_W-1:0]  result
);
   import rdc_pkg::*;

   logic              busy_ff, busy_in;
   logic              phase_ff, phase_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   mmu_op_type        op_ff, op_in;
   logic [DATA_W-1:0] r_ff, r_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] sh_ff, sh_in;
   logic [DATA_W-1:0] m_ff, m_in;
   logic [DATA_W:0]   t;
   logic [DATA_W:0]   red;

   // One doubling or one addition per cycle, then a single conditional subtract.
   always_comb begin
      if (phase_ff) begin
         t = {1'b0, r_ff} + {1'b0, a_ff};
      end else if (op_ff == OP_REDUCE) begin
         t = {r_ff, sh_ff[DATA_W-1]};
      end else begin
         t = {r_ff, 1'b0};
      end
      red = (t >= {1'b0, m_ff}) ? (t - {1'b0, m_ff}) : t;
   end

   // Walk the multiplier bits (for a reduction, the operand bits) from the top, one bit per step.
   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      r_in     = r_ff;
      a_in     = a_ff;
      sh_in    = sh_ff;
      m_in     = m_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         cnt_in   = CNT_W'(DATA_W - 1);
         op_in    = req.op;
         r_in     = '0;
         a_in     = req.a;
         sh_in    = req.b;
         m_in     = req.m;
      end else if (busy_ff) begin
         r_in = red[DATA_W-1:0];
         if (!phase_ff && op_ff == OP_MULT && sh_ff[DATA_W-1]) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            sh_in    = sh_ff << 1;
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
      r_ff   <= r_in;
      a_ff   <= a_in;
      sh_ff  <= sh_in;
      m_ff   <= m_in;
   end

   assign done   = done_ff;
   assign result = r_ff;

`ifndef SYNTHESIS
   // A multiplication's accumulator stays reduced.
   a_red: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && op_ff == OP_MULT) |-> (r_ff < m_ff))
      else $error("modular accumulator not reduced");
   // Completion is flagged exactly once when the unit goes idle.
   a_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !busy_in && !req.start) |=> done_ff)
      else $error("missing completion flag");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("completion while busy");
`endif

endmodule

// ===== sv/rsa_decrypt_direct_and_crt_top.sv =====
// Each modular multiplication runs bit-serially; an exponentiation walks all 64 exponent bits
// by square and multiply. Direct mode needs one exponentiation, CRT mode two plus two weighted
// multiplications. One item at a time: a new ciphertext is taken only when idle, after the last
// result has moved to the output register; the single bit-serial modular unit does the arithmetic.
// Reset: synchronous, active high; configuration registers return to mode 0, primes 2, all else 0;
// the datapath registers are not reset.
module rsa_decrypt_direct_and_crt_top #(
   parameter int PRIME_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rdc_pkg::DATA_W-1:0]    req_tdata,   // [63:0] ciphertext
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rdc_pkg::DATA_W-1:0]    rsp_tdata,   // [63:0] plaintext
   input  logic                          csr_we,
   input  logic [rdc_pkg::IDX_W-1:0]     csr_index,
   input  logic [rdc_pkg::DATA_W-1:0]    csr_wdata
);
   import rdc_pkg::*;

   // Configuration registers.
   logic                  mode_ff;
   logic [PRIME_BITS-1:0] p_ff, q_ff;
   logic [DATA_W-1:0]     d_ff, wp_ff, wq_ff;
   logic [31:0]           dp_ff, dq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         p_ff    <= PRIME_BITS'(2);
         q_ff    <= PRIME_BITS'(2);
         d_ff    <= '0;
         dp_ff   <= '0;
         dq_ff   <= '0;
         wp_ff   <= '0;
         wq_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MODE: mode_ff <= csr_wdata[0];
            REG_P:    p_ff    <= csr_wdata[PRIME_BITS-1:0];
            REG_Q:    q_ff    <= csr_wdata[PRIME_BITS-1:0];
            REG_D:    d_ff    <= csr_wdata;
            REG_DP:   dp_ff   <= csr_wdata[31:0];
            REG_DQ:   dq_ff   <= csr_wdata[31:0];
            REG_WP:   wp_ff   <= csr_wdata;
            REG_WQ:   wq_ff   <= csr_wdata;
            default:  ;
         endcase
      end
   end

   state_type         state_ff, state_in;
   leg_type           leg_ff, leg_in;
   logic              wsel_ff, wsel_in;
   logic              out_v_ff, out_v_in;
   logic [CNT_W-1:0]  ecnt_ff, ecnt_in;
   logic [DATA_W-1:0] c_ff, c_in;
   logic [DATA_W-1:0] n_ff, n_in;
   logic [DATA_W-1:0] mod_ff, mod_in;
   logic [DATA_W-1:0] base_ff, base_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] exp_ff, exp_in;
   logic [DATA_W-1:0] vp_ff, vp_in;
   logic [DATA_W-1:0] vq_ff, vq_in;
   logic [DATA_W-1:0] tp_ff, tp_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [DATA_W-1:0] out_ff, out_in;
   logic [DATA_W:0]   sum;
   logic [DATA_W:0]   sum_red;
   mmu_req_type       mreq;
   logic              mdone;
   logic [DATA_W-1:0] mres;

   rdc_mmu u_mmu (
      .clock  (clock),
      .reset  (reset),
      .req    (mreq),
      .done   (mdone),
      .result (mres)
   );

   // Final CRT combine of the two weighted residues.
   assign sum     = {1'b0, tp_ff} + {1'b0, acc_ff};
   assign sum_red = (sum >= {1'b0, n_ff}) ? (sum - {1'b0, n_ff}) : sum;

   // Sequencer for reductions, square-and-multiply and the CRT combine.
   always_comb begin
      state_in = state_ff;
      leg_in   = leg_ff;
      wsel_in  = wsel_ff;
      out_v_in = out_v_ff;
      ecnt_in  = ecnt_ff;
      c_in     = c_ff;
      n_in     = n_ff;
      mod_in   = mod_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      exp_in   = exp_ff;
      vp_in    = vp_ff;
      vq_in    = vq_ff;
      tp_in    = tp_ff;
      res_in   = res_ff;
      out_in   = out_ff;
      mreq     = '{start: 1'b0, op: OP_MULT, a: acc_ff, b: acc_ff, m: mod_ff};
      req_tready = (state_ff == ST_IDLE);

      if (out_v_ff && rsp_tready) begin
         out_v_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               c_in     = req_tdata;
               state_in = ST_MODN;
            end
         end
         ST_MODN: begin
            n_in     = DATA_W'(p_ff) * DATA_W'(q_ff);
            state_in = ST_SEL;
         end
         ST_SEL: begin
            wsel_in = 1'b0;
            if (n_ff == '0) begin
               res_in   = '0;
               state_in = ST_OUT;
            end else if (!mode_ff) begin
               leg_in   = LEG_DIRECT;
               mod_in   = n_ff;
               exp_in   = d_ff;
               state_in = ST_BRED;
            end else begin
               leg_in   = LEG_P;
               mod_in   = DATA_W'(p_ff);
               exp_in   = DATA_W'(dp_ff);
               state_in = ST_BRED;
            end
         end
         ST_BRED: begin
            mreq     = '{start: 1'b1, op: OP_REDUCE, a: '0, b: c_ff, m: mod_ff};
            state_in = ST_BRED_W;
         end
         ST_BRED_W: begin
            if (mdone) begin
               base_in  = mres;
               acc_in   = (mod_ff == DATA_W'(1)) ? '0 : DATA_W'(1);
               ecnt_in  = CNT_W'(DATA_W - 1);
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            mreq     = '{start: 1'b1, op: OP_MULT, a: acc_ff, b: acc_ff, m: mod_ff};
            state_in = ST_SQ_W;
         end
         ST_ML: begin
            mreq     = '{start: 1'b1, op: OP_MULT, a: base_ff, b: acc_ff, m: mod_ff};
            state_in = ST_ML_W;
         end
         ST_SQ_W, ST_ML_W: begin
            if (mdone) begin
               acc_in = mres;
               if (state_ff == ST_SQ_W && exp_ff[DATA_W-1]) begin
                  state_in = ST_ML;
               end else begin
                  exp_in = exp_ff << 1;
                  if (ecnt_ff == '0) begin
                     state_in = ST_PEND;
                  end else begin
                     ecnt_in  = ecnt_ff - 1'b1;
                     state_in = ST_SQ;
                  end
               end
            end
         end
         ST_PEND: begin
            unique case (leg_ff)
               LEG_DIRECT: begin
                  res_in   = acc_ff;
                  state_in = ST_OUT;
               end
               LEG_P: begin
                  vp_in    = acc_ff;
                  leg_in   = LEG_Q;
                  mod_in   = DATA_W'(q_ff);
                  exp_in   = DATA_W'(dq_ff);
                  state_in = ST_BRED;
               end
               default: begin
                  vq_in    = acc_ff;
                  state_in = ST_WRED;
               end
            endcase
         end
         ST_WRED: begin
            mreq     = '{start: 1'b1, op: OP_REDUCE, a: '0,
                         b: (wsel_ff ? wq_ff : wp_ff), m: n_ff};
            state_in = ST_WRED_W;
         end
         ST_WRED_W: begin
            if (mdone) begin
               base_in  = mres;
               state_in = ST_WMUL;
            end
         end
         ST_WMUL: begin
            mreq     = '{start: 1'b1, op: OP_MULT, a: base_ff,
                         b: (wsel_ff ? vq_ff : vp_ff), m: n_ff};
            state_in = ST_WMUL_W;
         end
         ST_WMUL_W: begin
            if (mdone) begin
               if (!wsel_ff) begin
                  tp_in    = mres;
                  wsel_in  = 1'b1;
                  state_in = ST_WRED;
               end else begin
                  acc_in   = mres;
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            res_in   = sum_red[DATA_W-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_v_ff || rsp_tready) begin
               out_v_in = 1'b1;
               out_in   = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         leg_ff   <= LEG_DIRECT;
         wsel_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         leg_ff   <= leg_in;
         wsel_ff  <= wsel_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      ecnt_ff <= ecnt_in;
      c_ff    <= c_in;
      n_ff    <= n_in;
      mod_ff  <= mod_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      exp_ff  <= exp_in;
      vp_ff   <= vp_in;
      vq_ff   <= vq_in;
      tp_ff   <= tp_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

`ifndef SYNTHESIS
   // The modular unit only reports completion while the sequencer waits for it.
   a_wait: assert property (@(posedge clock) disable iff (reset)
      mdone |-> (state_ff == ST_BRED_W || state_ff == ST_SQ_W || state_ff == ST_ML_W ||
                 state_ff == ST_WRED_W || state_ff == ST_WMUL_W))
      else $error("unexpected completion from modular unit");
   // Squaring always starts from a reduced accumulator.
   a_sq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ) |-> (acc_ff < mod_ff))
      else $error("accumulator not reduced before squaring");
   // Both weighted residues are reduced before the final combine.
   a_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (tp_ff < n_ff && acc_ff < n_ff))
      else $error("weighted residues not reduced");
`endif

endmodule
